[rtl/core/quantized_u8_matrix_vector_product_core_assert.svh]
// ----------------------------------------------------------------------------
// quantized_u8_matrix_vector_product_core assertion macros
// Clocked property checks with reset disable; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_U8_MATRIX_VECTOR_PRODUCT_CORE_ASSERT_SVH
`define QUANTIZED_U8_MATRIX_VECTOR_PRODUCT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define QMVP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define QMVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QMVP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define QMVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/qmvp_pkg.sv]
// ----------------------------------------------------------------------------
// qmvp_pkg
// Types and constants shared by the quantized matrix-vector product core.
// ----------------------------------------------------------------------------
`default_nettype none

package qmvp_pkg;

    localparam int ROW_LENGTH_W = 13;
    localparam int CFG_INDEX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MATRIX_ZP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VECTOR_ZP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS_EN      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQUANT_EN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_MULT   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_SHIFT  = 3'd6;

    // Operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    typedef struct packed {
        logic [7:0]              matrix_zp;
        logic [7:0]              vector_zp;
        logic [ROW_LENGTH_W-1:0] row_length;
        logic                    bias_en;
        logic                    requant_en;
        logic [30:0]             scale_mult;
        logic [4:0]              scale_shift;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        matrix_zp:   8'd0,
        vector_zp:   8'd0,
        row_length:  13'd1,
        bias_en:     1'b0,
        requant_en:  1'b0,
        scale_mult:  31'd1073741824,
        scale_shift: 5'd0
    };

    // Row-end job handed to the post-processing unit
    typedef struct packed {
        logic        start;
        logic [31:0] dot;
        logic [31:0] rsum;
        logic [31:0] vsum;
        logic [31:0] bias;
    } post_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } post_rsp_t;

endpackage

`default_nettype wire

[rtl/core/qmvp_post.sv]
// ----------------------------------------------------------------------------
// qmvp_post
// Row-end correction, bias and optional Q31 requantization, one step a cycle until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module qmvp_post #(
    parameter int LEN_W = 13
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire qmvp_pkg::cfg_t    cfg,
    input  wire logic [LEN_W-1:0]  len_eff,
    input  wire qmvp_pkg::post_cmd_t cmd,
    input  wire logic              take,
    output qmvp_pkg::post_rsp_t    rsp
);
    import qmvp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PROD = 7'b0000010,
        ST_CORR = 7'b0000100,
        ST_RAW  = 7'b0001000,
        ST_QMUL = 7'b0010000,
        ST_QRND = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] dot_reg, rsum_reg, vsum_reg, bias_reg;
    logic [31:0] t1_reg, t2_reg, acc_reg, zzl_reg;
    logic [15:0] zz_reg;
    logic [31:0] result_reg;
    logic [61:0] prod_reg;
    logic        neg_reg;

    logic [31:0] t1_next, t2_next, acc_next, raw_next;
    logic [15:0] zz_next;
    logic [LEN_W+15:0] zzl_full;
    logic [61:0] qprod;
    logic [63:0] rnd_sum, rq;
    logic [6:0]  rnd_pos, sh_amt;
    logic [31:0] clamp_next;

    assign t1_next  = 32'(rsum_reg * {24'd0, cfg.vector_zp});
    assign t2_next  = 32'(vsum_reg * {24'd0, cfg.matrix_zp});
    assign zz_next  = cfg.matrix_zp * cfg.vector_zp;
    assign zzl_full = zz_reg * len_eff;
    assign acc_next = dot_reg - t1_reg - t2_reg + (cfg.bias_en ? bias_reg : 32'd0);
    assign raw_next = acc_reg + zzl_reg;

    // Negative values clamp to zero, so only the low 31 bits need scaling
    assign qprod   = {31'd0, result_reg[30:0]} * {31'd0, cfg.scale_mult};
    assign rnd_pos = 7'd30 + {2'd0, cfg.scale_shift};
    assign sh_amt  = 7'd31 + {2'd0, cfg.scale_shift};
    assign rnd_sum = {2'd0, prod_reg} + (64'd1 << rnd_pos);
    assign rq      = rnd_sum >> sh_amt;

    always_comb
    begin
        if (neg_reg)
        begin
            clamp_next = 32'd0;
        end
        else if (rq > 64'd255)
        begin
            clamp_next = 32'd255;
        end
        else
        begin
            clamp_next = {24'd0, rq[7:0]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cmd.start) state_next = ST_PROD;
            ST_PROD: state_next = ST_CORR;
            ST_CORR: state_next = ST_RAW;
            ST_RAW:  state_next = cfg.requant_en ? ST_QMUL : ST_DONE;
            ST_QMUL: state_next = ST_QRND;
            ST_QRND: state_next = ST_DONE;
            ST_DONE: if (take) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd.start)
        begin
            dot_reg  <= cmd.dot;
            rsum_reg <= cmd.rsum;
            vsum_reg <= cmd.vsum;
            bias_reg <= cmd.bias;
        end
        if (state_reg == ST_PROD)
        begin
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            zz_reg <= zz_next;
        end
        if (state_reg == ST_CORR)
        begin
            acc_reg <= acc_next;
            zzl_reg <= zzl_full[31:0];
        end
        if (state_reg == ST_RAW)
        begin
            result_reg <= raw_next;
        end
        if (state_reg == ST_QMUL)
        begin
            prod_reg <= qprod;
            neg_reg  <= result_reg[31];
        end
        if (state_reg == ST_QRND)
        begin
            result_reg <= clamp_next;
        end
    end

    assign rsp.done  = (state_reg == ST_DONE);
    assign rsp.value = result_reg;

endmodule

`default_nettype wire

[rtl/core/quantized_u8_matrix_vector_product_core.sv]
// ----------------------------------------------------------------------------
// quantized_u8_matrix_vector_product_core
// Quantized uint8 matrix-vector product with zero points and requantization.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_stall): op 0 loads a vector element, op 1
//   streams a matrix element row-major; row_bias is sampled on a row's last
//   column. A transaction completes when valid is high and stall is low.
//   Result channel (result_valid/result_stall): one row_result per row.
//   Config channel (cfg_valid/cfg_ready): always ready; write while idle.
// Flow: loads and non-final matrix columns never raise item_stall; the vector
//   store read is registered with the element for multiply-accumulate.
//   A row's last column holds item_stall high while the post unit forms
//   the corrected raw int32 result and, when requantizing, runs its Q31 scaling,
//   until the result is taken into the output register; result_valid rises
//   in the same cycle that item_stall falls.
// A result waiting on result_stall sits in the output register; the next
//   row may stream meanwhile, and a further row end waits for that register.
// Reset clears configuration to defaults, accumulators and indexes. The
//   vector store has no reset; entries must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quantized_u8_matrix_vector_product_core_assert.svh"

module quantized_u8_matrix_vector_product_core #(
    parameter int MAX_ROW_LENGTH = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire logic                               op,
    input  wire logic [7:0]                         element,
    input  wire logic signed [31:0]                 row_bias,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic signed [31:0]                      row_result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [qmvp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [31:0]                        cfg_data
);
    import qmvp_pkg::*;

    localparam int IDX_W = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W = IDX_W + 1;
    localparam int CMP_W = (LEN_W > ROW_LENGTH_W) ? LEN_W : ROW_LENGTH_W;

    cfg_t cfg_reg;

    logic [7:0] vec_mem [MAX_ROW_LENGTH];
    logic [7:0] rd_data_reg;

    logic [IDX_W-1:0] load_idx_reg, load_idx_next;
    logic [IDX_W-1:0] col_idx_reg, col_idx_next;
    logic [31:0]      vsum_reg, vsum_next;
    logic [31:0]      dot_reg, dot_next;
    logic [31:0]      rsum_reg, rsum_next;
    logic             busy_reg, busy_next;

    logic             s1_valid_reg, s1_last_reg;
    logic [7:0]       s1_elem_reg;
    logic [31:0]      s1_bias_reg;

    logic             result_valid_reg;
    logic [31:0]      result_data_reg;

    logic [CMP_W-1:0] row_len_ext;
    logic [LEN_W-1:0] len_eff, len_m1;
    logic [LEN_W-1:0] li_ext, li_inc, col_ext, col_inc;
    logic [IDX_W-1:0] load_addr, rd_col;
    logic             item_fire, load_fire, mat_fire, col_last, take;
    logic [15:0]      prod;
    logic [31:0]      dot_sum, rsum_sum;

    post_cmd_t post_cmd;
    post_rsp_t post_rsp;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MATRIX_ZP:   cfg_reg.matrix_zp   <= cfg_data[7:0];
                CFG_VECTOR_ZP:   cfg_reg.vector_zp   <= cfg_data[7:0];
                CFG_ROW_LENGTH:  cfg_reg.row_length  <= cfg_data[ROW_LENGTH_W-1:0];
                CFG_BIAS_EN:     cfg_reg.bias_en     <= cfg_data[0];
                CFG_REQUANT_EN:  cfg_reg.requant_en  <= cfg_data[0];
                CFG_SCALE_MULT:  cfg_reg.scale_mult  <= cfg_data[30:0];
                CFG_SCALE_SHIFT: cfg_reg.scale_shift <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Effective row length: zero acts as one, clamp to the store depth
    assign row_len_ext = CMP_W'(cfg_reg.row_length);

    always_comb
    begin
        if (row_len_ext == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (row_len_ext > CMP_W'(MAX_ROW_LENGTH))
        begin
            len_eff = LEN_W'(MAX_ROW_LENGTH);
        end
        else
        begin
            len_eff = row_len_ext[LEN_W-1:0];
        end
    end

    assign len_m1 = len_eff - LEN_W'(1);

    assign item_stall = busy_reg;
    assign item_fire  = item_valid && !item_stall;
    assign load_fire  = item_fire && (op == OP_LOAD);
    assign mat_fire   = item_fire && (op == OP_MATRIX);

    // Load position: wrap when the row length shrank below it
    assign li_ext    = {1'b0, load_idx_reg};
    assign load_addr = (li_ext >= len_eff) ? '0 : load_idx_reg;
    assign li_inc    = {1'b0, load_addr} + LEN_W'(1);
    assign load_idx_next = (li_inc >= len_eff) ? '0 : li_inc[IDX_W-1:0];
    assign vsum_next = ((load_addr == '0) ? 32'd0 : vsum_reg) + {24'd0, element};

    // Column position: anything at or past the end counts as the last column
    assign col_ext  = {1'b0, col_idx_reg};
    assign rd_col   = (col_ext < len_eff) ? col_idx_reg : len_m1[IDX_W-1:0];
    assign col_inc  = col_ext + LEN_W'(1);
    assign col_last = (col_inc >= len_eff);
    assign col_idx_next = col_last ? '0 : col_inc[IDX_W-1:0];

    // Vector store: write on load, registered read for the column being accepted
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            vec_mem[load_addr] <= element;
        end
        if (mat_fire)
        begin
            rd_data_reg <= vec_mem[rd_col];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
            vsum_reg     <= '0;
            col_idx_reg  <= '0;
        end
        else
        begin
            if (load_fire)
            begin
                load_idx_reg <= load_idx_next;
                vsum_reg     <= vsum_next;
            end
            if (mat_fire)
            begin
                col_idx_reg <= col_idx_next;
            end
        end
    end

    // Multiply-accumulate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= mat_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat_fire)
        begin
            s1_last_reg <= col_last;
            s1_elem_reg <= element;
            s1_bias_reg <= row_bias;
        end
    end

    assign prod     = s1_elem_reg * rd_data_reg;
    assign dot_sum  = dot_reg + {16'd0, prod};
    assign rsum_sum = rsum_reg + {24'd0, s1_elem_reg};

    always_comb
    begin
        dot_next  = dot_reg;
        rsum_next = rsum_reg;
        if (s1_valid_reg)
        begin
            dot_next  = s1_last_reg ? 32'd0 : dot_sum;
            rsum_next = s1_last_reg ? 32'd0 : rsum_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            rsum_reg <= '0;
        end
        else
        begin
            dot_reg  <= dot_next;
            rsum_reg <= rsum_next;
        end
    end

    assign post_cmd.start = s1_valid_reg && s1_last_reg;
    assign post_cmd.dot   = dot_sum;
    assign post_cmd.rsum  = rsum_sum;
    assign post_cmd.vsum  = vsum_reg;
    assign post_cmd.bias  = s1_bias_reg;

    qmvp_post #(
        .LEN_W (LEN_W)
    ) u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .len_eff (len_eff),
        .cmd     (post_cmd),
        .take    (take),
        .rsp     (post_rsp)
    );

    // Hold input from a row end until its result reaches the output register
    assign take = post_rsp.done && (!result_valid_reg || !result_stall);

    always_comb
    begin
        busy_next = busy_reg;
        priority if (mat_fire && col_last)
        begin
            busy_next = 1'b1;
        end
        else if (take)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (take)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_data_reg <= post_rsp.value;
        end
    end

    assign result_valid = result_valid_reg;
    assign row_result   = result_data_reg;

    `QMVP_ASSERT_NEXT(a_row_end_busy, clk, rst_n, (mat_fire && col_last), busy_reg, "row end did not raise stall")
    `QMVP_ASSERT_IMPL(a_post_done_busy, clk, rst_n, post_rsp.done, busy_reg, "post result without busy")
    `QMVP_ASSERT_IMPL(a_s1_last_busy, clk, rst_n, (s1_valid_reg && s1_last_reg), busy_reg, "row end launched while accepting")
    `QMVP_ASSERT_IMPL(a_rd_in_range, clk, rst_n, mat_fire, ({1'b0, rd_col} < len_eff), "store read beyond row length")

endmodule

`default_nettype wire
